FILE: hdl/itaf_pkg.sv
`default_nettype none

package itaf_pkg;

  // Format selector codes.
  localparam logic [1:0] CMD_SDEC   = 2'd0;
  localparam logic [1:0] CMD_UDEC   = 2'd1;
  localparam logic [1:0] CMD_HEX    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DecBits   = 32;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = ValueW / 4;
  localparam int unsigned BcdW      = 4 * DecDigits;
  localparam int unsigned NdigW     = $clog2(HexDigits + 1);
  localparam int unsigned StepCntW  = $clog2(DecBits);

  localparam logic [CharW-1:0] CHAR_MINUS     = 8'h2d;
  localparam logic [CharW-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [CharW-1:0] CHAR_X         = 8'h78;
  localparam logic [CharW-1:0] DIGIT_BASE     = 8'd48;
  localparam logic [CharW-1:0] HEX_ALPHA_BASE = 8'd55;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_STRIP = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_PRE0  = 7'b0010000,
    S_PREX  = 7'b0100000,
    S_DIGIT = 7'b1000000
  } itaf_state_e;

  // ASCII code of one hex or decimal digit.
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    logic [CharW-1:0] r;
    if (d < 4'd10) begin
      r = DIGIT_BASE + CharW'(d);
    end else begin
      r = HEX_ALPHA_BASE + CharW'(d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/itaf_in_if.sv
`default_nettype none

interface itaf_in_if
  import itaf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [ValueW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/itaf_out_if.sv
`default_nettype none

interface itaf_out_if
  import itaf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/itaf_dabble.sv
`default_nettype none

// Binary to BCD converter: one shift-and-add-3 step per cycle over the DecBits input bits.
module itaf_dabble
  import itaf_pkg::*;
(
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               start_i,
  input  var logic [DecBits-1:0] bin_i,
  output var logic               done_o,
  output var logic [BcdW-1:0]    bcd_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [DecBits-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]     adj;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = StepCntW'(DecBits - 1);
      bcd_d  = '0;
      bin_d  = bin_i;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[DecBits-1]};
      bin_d = {bin_q[DecBits-2:0], 1'b0};
      cnt_d = cnt_q - StepCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

FILE: hdl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter.
//
// The input channel takes one beat per value: a format selector (cmd) and a
// 64-bit value. Selector 0 prints bits 31..0 as signed decimal, 1 as unsigned
// decimal, and 2 prints all 64 bits as upper-case hex after "0x". Selector 3
// is dropped and produces no output. The output channel gives one character
// per beat, most significant digit first, with last set on the final one.
//
// Sequence: a decimal value first runs through the binary-to-BCD converter
// (shift-and-add-3 steps, then the digits are handed over); then its leading
// zero digits are suppressed one at a time, and then its characters are sent,
// the sign first for a negative value. A hex value skips the converter, has
// its leading zeros suppressed the same way, then sends "0x" and its digits.
// Fewer leading zeros mean more characters. The input is ready only while the
// sequencer is idle, so a new value is not taken before the last one is
// through; a dropped selector leaves the input open.
//
// The output register holds a character until the receiver takes it; a
// stalled receiver simply pauses the sequencer. Reset clears the sequencer
// to idle and drops the output valid.
`default_nettype none

module integer_to_ascii_formatter_unit
  import itaf_pkg::*;
(
  input  var logic clk_i,
  input  var logic rst_ni,
  itaf_in_if.sink  in_i,
  itaf_out_if.source out_o
);

  localparam int unsigned PadW = ValueW - BcdW;

  itaf_state_e state_q, state_d;
  logic              neg_q, neg_d;
  logic              hex_q, hex_d;
  logic [ValueW-1:0] dig_q, dig_d;
  logic [NdigW-1:0]  ndig_q, ndig_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;

  logic               accept;
  logic               out_free;
  logic [DecBits-1:0] low;
  logic               neg_in;
  logic [DecBits-1:0] mag;
  logic               dab_start;
  logic               dab_done;
  logic [BcdW-1:0]    dab_bcd;
  logic               emit;
  logic [CharW-1:0]   emit_char;
  logic               emit_last;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // The magnitude is formed in unsigned arithmetic, so the most negative
  // value comes out as its full magnitude.
  assign low    = in_i.value[DecBits-1:0];
  assign neg_in = (in_i.cmd == CMD_SDEC) && low[DecBits-1];
  assign mag    = neg_in ? (~low + DecBits'(1)) : low;

  itaf_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .bin_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    hex_d     = hex_q;
    dig_d     = dig_q;
    ndig_d    = ndig_q;
    dab_start = 1'b0;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            CMD_SDEC, CMD_UDEC: begin
              dab_start = 1'b1;
              neg_d     = neg_in;
              hex_d     = 1'b0;
              state_d   = S_CONV;
            end
            CMD_HEX: begin
              dig_d   = in_i.value;
              ndig_d  = NdigW'(HexDigits);
              neg_d   = 1'b0;
              hex_d   = 1'b1;
              state_d = S_STRIP;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        if (dab_done) begin
          dig_d   = {dab_bcd, PadW'(0)};
          ndig_d  = NdigW'(DecDigits);
          state_d = S_STRIP;
        end
      end
      S_STRIP: begin
        // Drop leading zero digits, but always keep the final one.
        if ((ndig_q != NdigW'(1)) && (dig_q[ValueW-1 -: 4] == 4'd0)) begin
          dig_d  = {dig_q[ValueW-5:0], 4'd0};
          ndig_d = ndig_q - NdigW'(1);
        end else if (hex_q) begin
          state_d = S_PRE0;
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHAR_MINUS;
          state_d   = S_DIGIT;
        end
      end
      S_PRE0: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHAR_ZERO;
          state_d   = S_PREX;
        end
      end
      S_PREX: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHAR_X;
          state_d   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = digit_char(dig_q[ValueW-1 -: 4]);
          emit_last = (ndig_q == NdigW'(1));
          dig_d     = {dig_q[ValueW-5:0], 4'd0};
          ndig_d    = ndig_q - NdigW'(1);
          if (ndig_q == NdigW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loads on emit, clears once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      char_d      = emit_char;
      last_d      = emit_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    hex_q  <= hex_d;
    dig_q  <= dig_d;
    ndig_q <= ndig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

`default_nettype wire

FILE: hdl/itaf_checker.sv
`default_nettype none

module itaf_checker
  import itaf_pkg::*;
(
  input var logic              clk_i,
  input var logic              rst_ni,
  input var logic              in_valid_i,
  input var logic              in_ready_i,
  input var logic [CmdW-1:0]   in_cmd_i,
  input var logic              out_valid_i,
  input var logic              out_ready_i,
  input var logic [CharW-1:0]  out_character_i,
  input var logic              out_last_i
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_character_i) && $stable(out_last_i)))
    else $error("output beat changed while stalled");

  // A value with a valid selector keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_cmd_i != CMD_UNUSED)) |=> !in_ready_i)
    else $error("input ready while a value is in conversion");

  // An unused selector is dropped and the input stays open.
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_cmd_i == CMD_UNUSED)) |=> in_ready_i)
    else $error("unused selector was not dropped");

  // Every character is a digit, a minus sign, an x or a hex letter.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((out_character_i >= 8'h30 && out_character_i <= 8'h39) ||
       (out_character_i >= 8'h41 && out_character_i <= 8'h46) ||
       (out_character_i == CHAR_MINUS) || (out_character_i == CHAR_X)))
    else $error("character outside the expected set");

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_cmd_i        (in_i.cmd),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_i      (out_o.last)
);

`default_nettype wire

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itaf_pkg::*;

  // Cycles without any beat on either channel before the run is abandoned. The longest
  // legitimate quiet spell is the deliberate receiver hold-off below (RxHoldCycles); a
  // decimal value otherwise waits for the converter before its first character.
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned RxHoldCycles = 300;
  // Drain time after the last expected character: covers a dropped selector or a
  // stray character that would still come out of the converter.
  localparam int unsigned DrainCycles  = 64;
  localparam int unsigned RandomValues = 450;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  // One row of the directed table. Where has_text is set, text is the exact output
  // (empty for a dropped selector); otherwise the expected text is computed.
  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] value;
    bit          has_text;
    string       text;
  } value_row_t;

  localparam int unsigned NumRows = 22;

  value_row_t value_rows [NumRows] = '{
    '{CMD_SDEC,   64'h0,                  1'b1, "0"},
    '{CMD_UDEC,   64'h0,                  1'b1, "0"},
    '{CMD_HEX,    64'h0,                  1'b1, "0x0"},
    '{CMD_SDEC,   64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
    '{CMD_SDEC,   64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"},
    '{CMD_SDEC,   64'h0000_0000_FFFF_FFFF, 1'b1, "-1"},
    '{CMD_UDEC,   64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
    '{CMD_UDEC,   64'h0000_0000_8000_0000, 1'b1, "2147483648"},
    '{CMD_HEX,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xFFFFFFFFFFFFFFFF"},
    '{CMD_HEX,    64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000"},
    '{CMD_UNUSED, 64'h0000_0000_0000_0123, 1'b1, ""},
    '{CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ""},
    '{CMD_SDEC,   64'hFFFF_FFFF_0000_0007, 1'b1, "7"},
    '{CMD_UDEC,   64'h1234_5678_0000_0000, 1'b1, "0"},
    '{CMD_HEX,    64'h0123_4567_89AB_CDEF, 1'b1, "0x123456789ABCDEF"},
    '{CMD_HEX,    64'h0000_0000_FEDC_BA98, 1'b0, ""},
    '{CMD_SDEC,   64'h0000_0000_3B9A_CA00, 1'b0, ""},
    '{CMD_UDEC,   64'h0000_0000_0000_0009, 1'b0, ""},
    '{CMD_UDEC,   64'h0000_0000_0000_000A, 1'b0, ""},
    '{CMD_SDEC,   64'h5555_5555_FFFF_FFF6, 1'b0, ""},
    '{CMD_HEX,    64'h0000_0000_0000_000A, 1'b0, ""},
    '{CMD_UDEC,   64'hAAAA_AAAA_DEAD_BEEF, 1'b0, ""}
  };

  logic clk = 1'b0;
  logic rst_n;

  itaf_in_if  in_if ();
  itaf_out_if out_if ();

  integer_to_ascii_formatter_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Characters still owed by the block, oldest first.
  char_beat_t pending_chars[$];

  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Knobs shared between the sender and the receiver process.
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned rx_hold = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Builds the text of one value: most significant character first. A dropped selector
  // leaves the text empty.
  function automatic void render_text(input logic [1:0] cmd, input logic [63:0] value,
                                      ref logic [7:0] text[$]);
    logic [31:0] mag;
    logic [63:0] rest;
    logic [3:0]  nib;
    bit          neg;
    text.delete();
    neg = 1'b0;
    case (cmd)
      CMD_SDEC, CMD_UDEC: begin
        mag = value[31:0];
        // The magnitude is taken modulo 2**32, so the most negative value keeps
        // its full size as an unsigned number.
        if (cmd == CMD_SDEC && mag[31]) begin
          neg = 1'b1;
          mag = 32'd0 - mag;
        end
        do begin
          text.push_front(CHAR_ZERO + 8'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (neg) begin
          text.push_front(CHAR_MINUS);
        end
      end
      CMD_HEX: begin
        rest = value;
        do begin
          nib = rest[3:0];
          if (nib < 4'd10) begin
            text.push_front(DIGIT_BASE + {4'b0, nib});
          end else begin
            text.push_front(HEX_ALPHA_BASE + {4'b0, nib});
          end
          rest = rest >> 4;
        end while (rest != 64'd0);
        text.push_front(CHAR_X);
        text.push_front(CHAR_ZERO);
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one value on the input channel after a random gap (none while tx_idle is clear),
  // waits for its beat, and then queues the characters it must produce. Valid stays high
  // across back-to-back values so that it is never lowered and raised within one step.
  task automatic offer_value(input logic [1:0] cmd, input logic [63:0] value,
                             input bit has_text, input string text);
    int unsigned gap;
    logic [7:0]  chars[$];
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.value <= value;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    if (has_text) begin
      for (int i = 0; i < text.len(); i++) begin
        chars.push_back(text[i]);
      end
    end else begin
      render_text(cmd, value, chars);
    end
    foreach (chars[i]) begin
      pending_chars.push_back('{character: chars[i], last: (i == chars.size() - 1)});
    end
  endtask

  // Lowers valid and waits until the block has emitted everything it owes.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Receiver: a random wait before each character, or a long hold-off on request.
  // A pending hold-off request also ends the wait for a character, so it takes effect
  // even while the output is empty.
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_if.valid && rx_hold == 0);
    end
  end

  // Output checker: every character beat is compared field by field with the oldest
  // character still owed.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("character 0x%02h (last %0b) with nothing pending",
                                out_if.character, out_if.last));
      end else begin
        want = pending_chars.pop_front();
        if (out_if.character !== want.character) begin
          flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                  out_if.character, want.character));
        end
        if (out_if.last !== want.last) begin
          flag_mismatch($sformatf("last %0b on character 0x%02h, expected %0b",
                                  out_if.last, want.character, want.last));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("%0t ns: no beat for %0d cycles", $realtime, QuietLimit);
      $display("[integer_to_ascii_formatter_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [63:0] value;
    logic [31:0] pow10;

    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd   <= CMD_SDEC;
    in_if.value <= 64'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: zero in every format, the signed and unsigned extremes, the most
    // negative value, hex with and without leading zeros, the dropped selector, and
    // upper bits that the decimal formats must ignore.
    for (int r = 0; r < NumRows; r++) begin
      offer_value(value_rows[r].cmd, value_rows[r].value, value_rows[r].has_text,
                  value_rows[r].text);
    end
    wait_drained();

    sent = 0;
    while (sent < RandomValues) begin
      // Change the idling pattern now and then; some stretches run at full rate.
      if (sent % 50 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      // Once early and once midway: the receiver stalls for a long stretch while values
      // keep coming, so the output fills and the input stalls. Afterwards the sender
      // waits until everything has come out.
      if (sent == 20 || sent == RandomValues / 2) begin
        rx_hold = RxHoldCycles;
      end
      if (sent == 30 || sent == RandomValues / 2 + 10) begin
        wait_drained();
      end

      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        cmd = CMD_UNUSED;
      end else if (pick < 7) begin
        cmd = CMD_SDEC;
      end else if (pick < 13) begin
        cmd = CMD_UDEC;
      end else begin
        cmd = CMD_HEX;
      end

      case ($urandom_range(0, 5))
        0: value = {$urandom(), $urandom()};
        1: value = {$urandom(), 32'($urandom_range(0, 20))};
        2: value = {$urandom(), 32'd0 - 32'($urandom_range(1, 20))};
        3: value = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        4: begin
          // Around a power of ten, where the digit count changes.
          pow10 = 32'd1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
          value = {$urandom(), pow10 - 32'd1 + 32'($urandom_range(0, 2))};
        end
        default: begin
          // Around a power of sixteen, where the hex digit count changes.
          value = (64'd1 << (4 * $urandom_range(0, 15))) - 64'($urandom_range(0, 1));
        end
      endcase

      offer_value(cmd, value, 1'b0, "");
      if (cmd != CMD_UNUSED) begin
        sent++;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[integer_to_ascii_formatter_unit] OK");
    end else begin
      $display("[integer_to_ascii_formatter_unit] ERROR");
    end
    $finish;
  end

endmodule
